// File: hw/rtl/sart_pkg.sv
// ============================================================================
// Sorted address region table package
// Shared constants, operation codes, status codes and the result record.
// ============================================================================
package sart_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int ADDR_WIDTH_DEF = 32;
    localparam int FIELD_W        = 32;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_HIT      = 2'd2,
        ST_MISS     = 2'd3
    } t_status;

    typedef struct packed {
        t_status              status;
        logic [FIELD_W-1:0]   found_length;
        logic [FIELD_W-1:0]   found_start;
    } t_result;

endpackage

// File: hw/rtl/sart_mem.sv
// ============================================================================
// Region store
// Single-write, single-read memory with a registered read port.
// ============================================================================
module sart_mem #(
    parameter int DEPTH = sart_pkg::CAPACITY_DEF,
    parameter int WIDTH = 2 * sart_pkg::ADDR_WIDTH_DEF + 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/sart_seq.sv
// ============================================================================
// Region table sequencer
// Binary search, entry shift and insert/lookup control over one shared memory read port.
// ============================================================================
module sart_seq #(
    parameter int CAPACITY   = sart_pkg::CAPACITY_DEF,
    parameter int ADDR_WIDTH = sart_pkg::ADDR_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_ready,
    input  logic                                  i_func,
    input  logic [ADDR_WIDTH-1:0]                 i_key,
    input  logic [ADDR_WIDTH-1:0]                 i_len,
    output logic                                  o_res_valid,
    input  logic                                  i_res_ready,
    output sart_pkg::t_result                     o_res,
    output logic                                  o_we,
    output logic [$clog2(CAPACITY)-1:0]           o_waddr,
    output logic [2*ADDR_WIDTH:0]                 o_wdata,
    output logic [$clog2(CAPACITY)-1:0]           o_raddr,
    input  logic [2*ADDR_WIDTH:0]                 i_rdata
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = ADDR_WIDTH + 1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SRCH = 8'b0000_0010,
        S_CMP  = 8'b0000_0100,
        S_LCHK = 8'b0000_1000,
        S_SHRD = 8'b0001_0000,
        S_SHWR = 8'b0010_0000,
        S_INS  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state                r_state, n_state;
    logic                  r_func, n_func;
    logic [ADDR_WIDTH-1:0] r_key, n_key;
    logic [ADDR_WIDTH-1:0] r_len, n_len;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_lo, n_lo;
    logic [CW-1:0]         r_hi, n_hi;
    logic [CW-1:0]         r_k, n_k;
    sart_pkg::t_result     r_res, n_res;

    logic [CW:0]           w_sum;
    logic [CW-1:0]         w_mid;
    logic [CW-1:0]         w_km1;
    logic [EW-1:0]         w_rd_end;
    logic [ADDR_WIDTH-1:0] w_rd_start;
    logic [EW-1:0]         w_new_end;
    logic                  w_key_below_end;
    logic                  w_start_le_key;
    logic                  w_lo_lt_hi;

    assign w_sum      = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid      = w_sum[CW:1];
    assign w_km1      = r_k - CW'(1);
    assign w_rd_end   = i_rdata[2*ADDR_WIDTH:ADDR_WIDTH];
    assign w_rd_start = i_rdata[ADDR_WIDTH-1:0];
    assign w_new_end  = {1'b0, r_key} + {1'b0, r_len};
    assign w_lo_lt_hi = r_lo < r_hi;

    // The end comparator drives every search step and, with the start comparator, the hit test.
    assign w_key_below_end = {1'b0, r_key} < w_rd_end;
    assign w_start_le_key  = w_rd_start <= r_key;

    always_comb begin
        if (r_state == S_SHRD) begin
            o_raddr = w_km1[IW-1:0];
        end else if (w_lo_lt_hi) begin
            o_raddr = w_mid[IW-1:0];
        end else begin
            o_raddr = r_lo[IW-1:0];
        end
    end

    always_comb begin
        o_we    = 1'b0;
        o_waddr = r_lo[IW-1:0];
        o_wdata = {w_new_end, r_key};
        if (r_state == S_SHWR) begin
            o_we    = 1'b1;
            o_waddr = r_k[IW-1:0];
            o_wdata = i_rdata;
        end else if (r_state == S_INS) begin
            o_we    = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        n_func  = r_func;
        n_key   = r_key;
        n_len   = r_len;
        n_count = r_count;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_k     = r_k;
        n_res   = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_func = i_func;
                    n_key  = i_key;
                    n_len  = i_len;
                    n_lo   = '0;
                    n_hi   = r_count;
                    if (i_func == sart_pkg::FUNC_INSERT && r_count == CW'(CAPACITY)) begin
                        n_res   = '{status: sart_pkg::ST_FULL, default: '0};
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SRCH;
                    end
                end
            end
            S_SRCH: begin
                if (w_lo_lt_hi) begin
                    n_state = S_CMP;
                end else if (r_func == sart_pkg::FUNC_INSERT) begin
                    n_k     = r_count;
                    n_state = S_SHRD;
                end else if (r_lo < r_count) begin
                    n_state = S_LCHK;
                end else begin
                    n_res   = '{status: sart_pkg::ST_MISS, default: '0};
                    n_state = S_DONE;
                end
            end
            S_CMP: begin
                if (w_key_below_end) begin
                    n_hi = w_mid;
                end else begin
                    n_lo = w_mid + CW'(1);
                end
                n_state = S_SRCH;
            end
            S_LCHK: begin
                if (w_start_le_key && w_key_below_end) begin
                    n_res.status       = sart_pkg::ST_HIT;
                    n_res.found_start  = sart_pkg::FIELD_W'(w_rd_start);
                    n_res.found_length = sart_pkg::FIELD_W'(w_rd_end - {1'b0, w_rd_start});
                end else begin
                    n_res = '{status: sart_pkg::ST_MISS, default: '0};
                end
                n_state = S_DONE;
            end
            S_SHRD: begin
                if (r_k > r_lo) begin
                    n_state = S_SHWR;
                end else begin
                    n_state = S_INS;
                end
            end
            S_SHWR: begin
                n_k     = w_km1;
                n_state = S_SHRD;
            end
            S_INS: begin
                n_count = r_count + CW'(1);
                n_res   = '{status: sart_pkg::ST_INSERTED, default: '0};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_func <= n_func;
        r_key  <= n_key;
        r_len  <= n_len;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_k    <= n_k;
        r_res  <= n_res;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

// File: hw/rtl/sorted_address_region_table.sv
// A lookup runs s search steps, then checks the found region unless the search ends past the
// last region; s <= ceil(log2(n+1)) search steps over n stored regions. An insert searches
// alike, then moves m entries up one slot and writes the new region; a full table answers
// with no search. Throughput: one transaction at a time; the next is accepted once the
// sequencer is idle again, set by the single memory read port that serves every search step
// and move. Reset: synchronous, active low; empties the table and drops any pending result.
// ============================================================================
// Sorted address region table
// Holds address regions sorted by end address, inserts new regions in order
// and answers address lookups with the matching region.
// ============================================================================
module sorted_address_region_table #(
    parameter int CAPACITY   = sart_pkg::CAPACITY_DEF,
    parameter int ADDR_WIDTH = sart_pkg::ADDR_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [31:0] address, [63:32] length
    input  logic        i_s_axis_tuser,   // [0] func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [31:0] found_start, [63:32] found_length
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);

    localparam int IW = $clog2(CAPACITY);
    localparam int MW = 2 * ADDR_WIDTH + 1;

    // Each memory word holds one region: the exclusive end in the upper
    // ADDR_WIDTH+1 bits and the start in the lower ADDR_WIDTH bits.
    logic                  w_we;
    logic [IW-1:0]         w_waddr;
    logic [MW-1:0]         w_wdata;
    logic [IW-1:0]         w_raddr;
    logic [MW-1:0]         w_rdata;

    logic                  w_start;
    logic                  w_seq_ready;
    logic                  w_res_valid;
    logic                  w_res_ready;
    sart_pkg::t_result     w_res;

    logic [ADDR_WIDTH-1:0] w_key;
    logic [ADDR_WIDTH-1:0] w_len;

    logic                  r_m_valid;
    sart_pkg::t_result     r_m_res;

    // Incoming address and length are narrowed or zero-extended to the
    // internal address width before they reach the sequencer.
    assign w_key   = ADDR_WIDTH'(i_s_axis_tdata[31:0]);
    assign w_len   = ADDR_WIDTH'(i_s_axis_tdata[63:32]);

    // A new transaction is taken whenever the sequencer is idle, even while
    // the previous result still waits in the output register.
    assign o_s_axis_tready = w_seq_ready;
    assign w_start         = i_s_axis_tvalid && w_seq_ready;

    sart_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (MW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    sart_seq #(
        .CAPACITY   (CAPACITY),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .o_ready     (w_seq_ready),
        .i_func      (i_s_axis_tuser),
        .i_key       (w_key),
        .i_len       (w_len),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    // Output register: it can take a new result in the same cycle that the
    // downstream side drains the old one.
    assign w_res_ready = !r_m_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
        if (w_res_valid && w_res_ready) begin
            r_m_res <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {r_m_res.found_length, r_m_res.found_start};
    assign o_m_axis_tuser  = r_m_res.status;

endmodule

// File: hw/rtl/sart_chk.sv
// ============================================================================
// Region table port checker
// Watches the stream ports of the region table for ordering and result rules.
// ============================================================================
module sart_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [63:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    logic       w_in_acc;
    logic       w_out_acc;
    logic [1:0] r_outst;

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;

    // Transactions accepted but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outst <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_outst <= r_outst + 2'd1;
        end else if (!w_in_acc && w_out_acc) begin
            r_outst <= r_outst - 2'd1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed or vanished while stalled");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> r_outst != 2'd0)
        else $error("result shown with no transaction outstanding");

    a_outst_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outst != 2'd3)
        else $error("more than two transactions in flight");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != sart_pkg::ST_HIT |-> o_m_axis_tdata == 64'd0)
        else $error("non-hit result carries region data");

endmodule

bind sorted_address_region_table sart_chk u_sart_chk (.*);
